// ===== sv/akf_pkg.sv =====
// Shared types, constants and helpers for the angle Kalman filter.
`timescale 1ns / 1ps
package akf_pkg;

	localparam int NUM_W = 60;
	localparam int DEN_W = 34;

	typedef logic signed [69:0] wide_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		REG_Q_ANGLE   = 2'd0,
		REG_Q_GYRO    = 2'd1,
		REG_R_ANGLE   = 2'd2,
		REG_TIME_STEP = 2'd3
	} reg_idx_t;

	localparam logic [31:0] Q_ANGLE_RST   = 32'd42949673;
	localparam logic [31:0] Q_GYRO_RST    = 32'd1288490;
	localparam logic [31:0] R_ANGLE_RST   = 32'd42949673;
	localparam logic [23:0] TIME_STEP_RST = 24'd671089;

	function automatic wide_t ext32(input logic [31:0] v);
		return {{38{v[31]}}, v};
	endfunction

	function automatic logic [31:0] sat32(input wide_t v);
		logic [31:0] r;
		if (v > 70'sd2147483647)
			r = 32'h7fff_ffff;
		else if (v < -70'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== sv/akf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module akf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [akf_pkg::NUM_W-1:0]     num,
	input  logic [akf_pkg::DEN_W-1:0]     den,
	output logic                          done,
	output logic [akf_pkg::NUM_W-1:0]     quot
);

	logic                        busy_q;
	logic                        done_q;
	logic [5:0]                  cnt_q;
	logic [akf_pkg::DEN_W-1:0]   den_q;
	logic [akf_pkg::DEN_W-1:0]   rem_q;
	logic [akf_pkg::NUM_W-1:0]   quo_q;
	logic [akf_pkg::DEN_W:0]     shifted;
	logic [akf_pkg::DEN_W:0]     trial;

	assign shifted = {rem_q, quo_q[akf_pkg::NUM_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 6'(akf_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			if (!trial[akf_pkg::DEN_W]) begin
				rem_q <= trial[akf_pkg::DEN_W-1:0];
				quo_q <= {quo_q[akf_pkg::NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[akf_pkg::DEN_W-1:0];
				quo_q <= {quo_q[akf_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== sv/angle_kalman_filter.sv =====
// Top level of the one-axis angle/bias Kalman filter.
`timescale 1ns / 1ps
// Usage:
//   s_tdata carries one sample (accelerometer angle Q9.16, gyro rate Q12.16).
//   m_tdata returns the fused angle and the bias estimate, Q16.16. The user sets
//   noise terms and sample period over the APB port only while idle (not enforced).
// Processing:
//   A sample runs through eleven multiply/accumulate steps on one shared 34x34
//   multiplier, each a multiply state and an accumulate state, plus two gain
//   divisions in a bit-serial divider. When the innovation variance is not
//   positive the divisions and correction steps are skipped.
//   s_tready is high only while no sample is in work.
// Reset:
//   Estimates and covariance clear to zero, registers take their defaults,
//   no result is pending.
// Stall:
//   A result waits in the output register until m_tready; the next sample may
//   be taken meanwhile, but its result is held back until the register frees.
module angle_kalman_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // [24:0] accel_angle, [52:25] gyro_rate, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] fused_angle, [63:32] rate_bias
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] q_angle_q, q_gyro_q, r_angle_q;
	logic [23:0] time_step_q;

	akf_pkg::state_t state_q, state_d;
	logic [3:0]  step_q;
	logic        sel_q;

	logic [24:0] acc_q;
	logic [27:0] rate_q;
	logic [31:0] angle_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	logic [35:0] tmp_q;
	logic [32:0] y_q;
	logic [31:0] k0_q, k1_q;
	logic signed [67:0] prod_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod_w;
	akf_pkg::wide_t     prod_x, r24, r28;
	logic signed [33:0] s_w;
	logic [28:0]        rq_w;
	logic               num_neg;
	logic [31:0]        num_abs;
	logic               div_start, div_done;
	logic [59:0]        div_quot;
	akf_pkg::wide_t     q_wide;
	logic [31:0]        k_w;
	logic               cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle_q   <= akf_pkg::Q_ANGLE_RST;
			q_gyro_q    <= akf_pkg::Q_GYRO_RST;
			r_angle_q   <= akf_pkg::R_ANGLE_RST;
			time_step_q <= akf_pkg::TIME_STEP_RST;
		end else if (cfg_wr) begin
			unique case (akf_pkg::reg_idx_t'(paddr[3:2]))
				akf_pkg::REG_Q_ANGLE:   q_angle_q   <= pwdata;
				akf_pkg::REG_Q_GYRO:    q_gyro_q    <= pwdata;
				akf_pkg::REG_R_ANGLE:   r_angle_q   <= pwdata;
				akf_pkg::REG_TIME_STEP: time_step_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (akf_pkg::reg_idx_t'(paddr[3:2]))
			akf_pkg::REG_Q_ANGLE:   prdata = q_angle_q;
			akf_pkg::REG_Q_GYRO:    prdata = q_gyro_q;
			akf_pkg::REG_R_ANGLE:   prdata = r_angle_q;
			akf_pkg::REG_TIME_STEP: prdata = {8'd0, time_step_q};
			default:                prdata = '0;
		endcase
	end

	// shared multiplier operands per step
	always_comb begin
		mul_b = $signed({10'd0, time_step_q});
		unique case (step_q)
			4'd0: mul_a = $signed({{6{rate_q[27]}}, rate_q}) - $signed({{2{bias_q[31]}}, bias_q});
			4'd1: mul_a = $signed({{2{ba_q[31]}}, ba_q}) + $signed({{2{ab_q[31]}}, ab_q});
			4'd2: mul_a = $signed({2'd0, q_angle_q});
			4'd3: mul_a = $signed({{2{bb_q[31]}}, bb_q});
			4'd4: mul_a = $signed({2'd0, q_gyro_q});
			default: mul_a = $signed({{2{k1_q[31]}}, k1_q});
		endcase
		unique case (step_q)
			4'd5: mul_a = $signed({{2{k0_q[31]}}, k0_q});
			4'd9, 4'd10: mul_a = $signed({{2{k0_q[31]}}, k0_q});
			default: ;
		endcase
		unique case (step_q)
			4'd5, 4'd6:  mul_b = $signed({y_q[32], y_q});
			4'd7, 4'd9:  mul_b = $signed({{2{aa_q[31]}}, aa_q});
			4'd8, 4'd10: mul_b = $signed({{2{ab_q[31]}}, ab_q});
			default: ;
		endcase
	end

	assign prod_w = mul_a * mul_b;
	assign prod_x = $signed({{2{prod_q[67]}}, prod_q});
	assign r24    = (prod_x + (70'sd1 <<< 23)) >>> 24;
	assign r28    = (prod_x + (70'sd1 <<< 27)) >>> 28;

	// innovation variance, r_angle taken to Q4.28 with rounding
	assign rq_w = 29'(({1'b0, r_angle_q} + 33'd8) >> 4);
	assign s_w  = $signed({{2{aa_q[31]}}, aa_q}) + $signed({5'd0, rq_w});

	// gain numerator: cov_aa for the first division, cov_ba for the second
	assign num_neg = (state_q == akf_pkg::ST_DIV) ? ba_q[31] : aa_q[31];
	always_comb begin
		logic [31:0] src;
		src     = (state_q == akf_pkg::ST_DIV) ? ba_q : aa_q;
		num_abs = num_neg ? (32'd0 - src) : src;
	end

	assign div_start = ((state_q == akf_pkg::ST_ACC) && (step_q == 4'd4) && (s_w > 34'sd0))
		|| ((state_q == akf_pkg::ST_DIV) && div_done && !sel_q);

	akf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({num_abs, 28'd0}),
		.den    (s_w),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sign of the finished quotient follows the numerator in use when it started
	always_comb begin
		q_wide = $signed({10'd0, div_quot});
		k_w    = akf_pkg::sat32((sel_q ? ba_q[31] : aa_q[31]) ? -q_wide : q_wide);
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			akf_pkg::ST_IDLE: if (s_tvalid) state_d = akf_pkg::ST_MUL;
			akf_pkg::ST_MUL:  state_d = akf_pkg::ST_ACC;
			akf_pkg::ST_ACC: begin
				if (step_q == 4'd4)
					state_d = (s_w > 34'sd0) ? akf_pkg::ST_DIV : akf_pkg::ST_DONE;
				else if (step_q == 4'd10)
					state_d = akf_pkg::ST_DONE;
				else
					state_d = akf_pkg::ST_MUL;
			end
			akf_pkg::ST_DIV:  if (div_done && sel_q) state_d = akf_pkg::ST_MUL;
			akf_pkg::ST_DONE: if (!m_tvalid || m_tready) state_d = akf_pkg::ST_IDLE;
			default:          state_d = akf_pkg::ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == akf_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= akf_pkg::ST_IDLE;
			step_q   <= '0;
			sel_q    <= 1'b0;
			m_tvalid <= 1'b0;
			angle_q  <= '0;
			bias_q   <= '0;
			aa_q     <= '0;
			ab_q     <= '0;
			ba_q     <= '0;
			bb_q     <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == akf_pkg::ST_DONE) && (!m_tvalid || m_tready))
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				akf_pkg::ST_IDLE: step_q <= '0;
				akf_pkg::ST_ACC: begin
					step_q <= step_q + 4'd1;
					sel_q  <= 1'b0;
					unique case (step_q)
						4'd0: angle_q <= akf_pkg::sat32(akf_pkg::ext32(angle_q) + r24);
						4'd2: aa_q <= akf_pkg::sat32($signed({{34{tmp_q[35]}}, tmp_q}) + r28);
						4'd3: begin
							ab_q <= akf_pkg::sat32(akf_pkg::ext32(ab_q) - r24);
							ba_q <= akf_pkg::sat32(akf_pkg::ext32(ba_q) - r24);
						end
						4'd4:  bb_q    <= akf_pkg::sat32(akf_pkg::ext32(bb_q) + r28);
						4'd5:  angle_q <= akf_pkg::sat32(akf_pkg::ext32(angle_q) + r28);
						4'd6:  bias_q  <= akf_pkg::sat32(akf_pkg::ext32(bias_q) + r28);
						4'd7:  ba_q    <= akf_pkg::sat32(akf_pkg::ext32(ba_q) - r28);
						4'd8:  bb_q    <= akf_pkg::sat32(akf_pkg::ext32(bb_q) - r28);
						4'd9:  aa_q    <= akf_pkg::sat32(akf_pkg::ext32(aa_q) - r28);
						4'd10: ab_q    <= akf_pkg::sat32(akf_pkg::ext32(ab_q) - r28);
						default: ;
					endcase
				end
				akf_pkg::ST_DIV: if (div_done) sel_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			acc_q  <= s_tdata[24:0];
			rate_q <= s_tdata[52:25];
		end
		if (state_q == akf_pkg::ST_MUL)
			prod_q <= prod_w;
		if ((state_q == akf_pkg::ST_ACC) && (step_q == 4'd1))
			tmp_q <= 36'(akf_pkg::ext32(aa_q) - r24);
		if ((state_q == akf_pkg::ST_ACC) && (step_q == 4'd4))
			y_q <= $signed({{8{acc_q[24]}}, acc_q}) - $signed({angle_q[31], angle_q});
		if ((state_q == akf_pkg::ST_DIV) && div_done) begin
			if (sel_q)
				k1_q <= k_w;
			else
				k0_q <= k_w;
		end
		if ((state_q == akf_pkg::ST_DONE) && (!m_tvalid || m_tready))
			m_tdata <= {bias_q, angle_q};
	end

endmodule

// ===== sv/akf_checker.sv =====
// Port-level checks for the angle Kalman filter, bound to the top level.
`timescale 1ns / 1ps
module akf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        pready
);

	// one sample in work at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again right after a request");

	// a result never appears the cycle after a request is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind angle_kalman_filter akf_checker u_akf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
